// ===== sv/chtr_pkg.sv =====
// shared types and codes for the convex hull trick line store
package chtr_pkg;

  // request kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_UNDO  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_NO_UNDO = 2'd3;

  // configuration register map (register index is address bit 2)
  localparam int unsigned PADDR_W       = 3;
  localparam logic        REG_LOWER_ENV = 1'b0;
  localparam logic        REG_DECR      = 1'b1;

  // line store read selection
  typedef enum logic [1:0] {
    RD_NONE,
    RD_PAIR,
    RD_ZERO,
    RD_POS
  } rd_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       add_init;
    logic       qry_init;
    rd_sel_e    rd_sel;
    logic       norm;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       acc_en;
    logic       add_dec;
    logic       add_commit;
    logic       rb_rd;
    logic       rb_apply;
    logic       ev_mul;
    logic       ev_add;
    logic       q_init;
    logic       q_step;
    logic       out_load;
    logic [1:0] out_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_lt2;
    logic       cnt_zero;
    logic       add_full;
    logic       undo_empty;
    logic       add_more;
    logic       q_more;
  } sts_t;

endpackage

// ===== sv/chtr_if.sv =====
// request and result channel interfaces

interface chtr_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic signed [31:0] point_x;

  modport source (output valid, kind, slope, intercept, point_x, input ready);
  modport sink   (input valid, kind, slope, intercept, point_x, output ready);
endinterface

interface chtr_rsp_if #(
  parameter int unsigned CW = 11
);
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [CW-1:0]      hull_size;
  logic [1:0]         status;

  modport source (output valid, value, hull_size, status, input ready);
  modport sink   (input valid, value, hull_size, status, output ready);
endinterface

// ===== sv/chtr_dp.sv =====
// datapath: line store, undo history, exact crossing compare, line evaluation
module chtr_dp #(
  parameter int unsigned MAX_LINES  = 1024,
  parameter int unsigned UNDO_DEPTH = 1024,
  localparam int unsigned CW  = $clog2(MAX_LINES + 1),
  localparam int unsigned AW  = $clog2(MAX_LINES),
  localparam int unsigned TW  = $clog2(UNDO_DEPTH + 1),
  localparam int unsigned UAW = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  chtr_pkg::cmd_t     cmd_i,
  output chtr_pkg::sts_t     sts_o,
  input  logic               lower_env_i,
  input  logic               decr_i,
  input  logic        [1:0]  kind_i,
  input  logic signed [31:0] slope_i,
  input  logic signed [31:0] intercept_i,
  input  logic signed [31:0] point_x_i,
  output logic signed [63:0] value_o,
  output logic [CW-1:0]      hull_size_o,
  output logic [1:0]         status_o
);

  typedef struct packed {
    logic [AW-1:0] pos;
    logic [CW-1:0] cnt;
    logic [63:0]   line;
  } undo_t;

  // latched request
  logic        [1:0]  kind_q;
  logic signed [31:0] a_q, b_q, x_q;

  // control counters
  logic [CW-1:0] count_q, lo_q, hi_q, pos_q;
  logic [TW-1:0] top_q;

  // memories
  logic [63:0] line_mem [MAX_LINES];
  undo_t       undo_mem [UNDO_DEPTH];
  logic [63:0] rd0_q, rd1_q;
  undo_t       urd_q;

  // crossing compare state
  logic signed [32:0] n3_q, n2_q;
  logic        [32:0] d3_q, d2_q;
  logic        [1:0]  rk3_q, rk2_q;
  logic               undef_q;
  logic signed [50:0] prod_q;
  logic        [1:0]  prod_idx_q;
  logic signed [66:0] acc_q;

  // evaluation state
  logic signed [63:0] p0_q, p1_q, u_q, v_q, ans_q;

  // output payload
  logic signed [63:0] out_value_q;
  logic [CW-1:0]      out_size_q;
  logic [1:0]         out_status_q;

  logic          flip;
  logic [CW:0]   sum_lh;
  logic [CW-1:0] mid, mid_m1, mid_p1;
  logic [TW-1:0] top_m1;

  assign flip   = lower_env_i != decr_i;
  assign sum_lh = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = sum_lh[CW:1];
  assign mid_m1 = mid - 1'b1;
  assign mid_p1 = mid + 1'b1;
  assign top_m1 = top_q - 1'b1;

  // status toward the controller
  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.cnt_lt2    = count_q < CW'(2);
    sts_o.cnt_zero   = count_q == '0;
    sts_o.add_full   = (pos_q >= CW'(MAX_LINES)) || (top_q >= TW'(UNDO_DEPTH));
    sts_o.undo_empty = top_q == '0;
    sts_o.add_more   = lo_q <= hi_q;
    sts_o.q_more     = lo_q < hi_q;
  end

  // read address selection
  logic [AW-1:0] addr0, addr1;
  logic          re;
  always_comb begin
    addr0 = '0;
    addr1 = '0;
    unique case (cmd_i.rd_sel)
      chtr_pkg::RD_PAIR: begin
        if (kind_q == chtr_pkg::KIND_ADD) begin
          addr0 = mid_m1[AW-1:0];
          addr1 = mid[AW-1:0];
        end else begin
          addr0 = mid[AW-1:0];
          addr1 = mid_p1[AW-1:0];
        end
      end
      chtr_pkg::RD_POS:  addr0 = pos_q[AW-1:0];
      chtr_pkg::RD_ZERO: addr0 = '0;
      default:           addr0 = '0;
    endcase
  end
  assign re = cmd_i.rd_sel != chtr_pkg::RD_NONE;

  // line store write selection
  logic          line_we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  always_comb begin
    line_we = cmd_i.add_commit || cmd_i.rb_apply;
    if (cmd_i.rb_apply) begin
      waddr = urd_q.pos;
      wdata = urd_q.line;
    end else begin
      waddr = pos_q[AW-1:0];
      wdata = {a_q, b_q};
    end
  end

  // line store, two registered read ports
  always_ff @(posedge clk_i) begin
    if (re) begin
      rd0_q <= line_mem[addr0];
      rd1_q <= line_mem[addr1];
    end
    if (line_we) begin
      line_mem[waddr] <= wdata;
    end
  end

  // undo history
  always_ff @(posedge clk_i) begin
    if (cmd_i.rb_rd) begin
      urd_q <= undo_mem[top_m1[UAW-1:0]];
    end
    if (cmd_i.add_commit) begin
      undo_mem[top_q[UAW-1:0]] <= '{pos: pos_q[AW-1:0], cnt: count_q, line: rd0_q};
    end
  end

  // crossing numerators and denominators, normalized to a non-negative denominator
  logic signed [32:0] n3, d3, n2, d2;
  logic signed [31:0] a0, b0, a1, b1;
  assign a0 = $signed(rd0_q[63:32]);
  assign b0 = $signed(rd0_q[31:0]);
  assign a1 = $signed(rd1_q[63:32]);
  assign b1 = $signed(rd1_q[31:0]);
  assign n3 = 33'(b_q) - 33'(b0);
  assign d3 = 33'(a0) - 33'(a_q);
  assign n2 = 33'(b1) - 33'(b0);
  assign d2 = 33'(a0) - 33'(a1);

  // rank: 0 minus infinity, 1 finite, 2 plus infinity
  function automatic logic [1:0] rank_of(logic signed [32:0] n, logic signed [32:0] d);
    logic [1:0] r;
    if (d != '0)      r = 2'd1;
    else if (n > 0)   r = 2'd2;
    else              r = 2'd0;
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm) begin
      n3_q    <= d3[32] ? -n3 : n3;
      d3_q    <= d3[32] ? 33'(-d3) : 33'(d3);
      n2_q    <= d2[32] ? -n2 : n2;
      d2_q    <= d2[32] ? 33'(-d2) : 33'(d2);
      rk3_q   <= rank_of(n3, d3);
      rk2_q   <= rank_of(n2, d2);
      undef_q <= ((d3 == '0) && (n3 == '0)) || ((d2 == '0) && (n2 == '0));
    end
  end

  // partial product of one numerator and one denominator half
  logic signed [32:0] op_n;
  logic        [32:0] op_d;
  logic signed [17:0] op_part;
  assign op_n    = cmd_i.mul_idx[1] ? n2_q : n3_q;
  assign op_d    = cmd_i.mul_idx[1] ? d3_q : d2_q;
  assign op_part = cmd_i.mul_idx[0] ? $signed({2'b00, op_d[32:17]})
                                    : $signed({1'b0, op_d[16:0]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= op_n * op_part;
      prod_idx_q <= cmd_i.mul_idx;
    end
  end

  // accumulate n3*d2 - n2*d3
  logic signed [66:0] term_ext, term_sh, term;
  assign term_ext = 67'(prod_q);
  assign term_sh  = prod_idx_q[0] ? (term_ext <<< 17) : term_ext;
  assign term     = prod_idx_q[1] ? -term_sh : term_sh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_q <= (prod_idx_q == 2'd0) ? term : acc_q + term;
    end
  end

  // replacement decision
  logic o_lt, o_gt, rep;
  always_comb begin
    if (rk3_q != rk2_q) begin
      o_lt = rk3_q < rk2_q;
      o_gt = rk3_q > rk2_q;
    end else if (rk3_q == 2'd1) begin
      o_lt = acc_q < 0;
      o_gt = acc_q > 0;
    end else begin
      o_lt = 1'b0;
      o_gt = 1'b0;
    end
    rep = !undef_q && (flip ? !o_lt : !o_gt);
  end

  // line evaluation at the query abscissa
  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_mul) begin
      p0_q <= a0 * x_q;
      p1_q <= a1 * x_q;
    end
    if (cmd_i.ev_add) begin
      u_q <= p0_q + 64'(b0);
      v_q <= p1_q + 64'(b1);
    end
  end

  // running min or max of visited values
  logic               go;
  logic signed [63:0] ans_t, ans_n;
  always_comb begin
    go = flip ? (u_q < v_q) : (u_q > v_q);
    if (lower_env_i) begin
      ans_t = (u_q < ans_q) ? u_q : ans_q;
      ans_n = (v_q < ans_t) ? v_q : ans_t;
    end else begin
      ans_t = (u_q > ans_q) ? u_q : ans_q;
      ans_n = (v_q > ans_t) ? v_q : ans_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_init) begin
      ans_q <= u_q;
    end else if (cmd_i.q_step) begin
      ans_q <= ans_n;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_i;
      a_q    <= slope_i;
      b_q    <= intercept_i;
      x_q    <= point_x_i;
    end
  end

  // hull count, undo top and search bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      top_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.add_init) begin
        lo_q  <= CW'(1);
        hi_q  <= count_q - 1'b1;
        pos_q <= count_q;
      end else if (cmd_i.qry_init) begin
        lo_q <= '0;
        hi_q <= count_q - 1'b1;
      end else if (cmd_i.add_dec) begin
        if (rep) begin
          pos_q <= mid;
          hi_q  <= mid_m1;
        end else begin
          lo_q <= mid_p1;
        end
      end else if (cmd_i.q_step) begin
        if (go) lo_q <= mid_p1;
        else    hi_q <= mid;
      end
      if (cmd_i.add_commit) begin
        count_q <= pos_q + 1'b1;
        top_q   <= top_q + 1'b1;
      end else if (cmd_i.rb_apply) begin
        count_q <= urd_q.cnt;
        top_q   <= top_m1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q  <= ((kind_q == chtr_pkg::KIND_QUERY) &&
                       (cmd_i.out_status == chtr_pkg::STAT_OK)) ? ans_q : '0;
      out_size_q   <= count_q;
      out_status_q <= cmd_i.out_status;
    end
  end

  assign value_o     = out_value_q;
  assign hull_size_o = out_size_q;
  assign status_o    = out_status_q;

endmodule

// ===== sv/chtr_ctrl.sv =====
// controller: sequences add, rollback and query requests over the datapath
module chtr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  chtr_pkg::sts_t sts_i,
  output chtr_pkg::cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_A_RD     = 5'd2;
  localparam logic [4:0] S_A_NORM   = 5'd3;
  localparam logic [4:0] S_A_M0     = 5'd4;
  localparam logic [4:0] S_A_M1     = 5'd5;
  localparam logic [4:0] S_A_M2     = 5'd6;
  localparam logic [4:0] S_A_M3     = 5'd7;
  localparam logic [4:0] S_A_M4     = 5'd8;
  localparam logic [4:0] S_A_DEC    = 5'd9;
  localparam logic [4:0] S_A_CHK    = 5'd10;
  localparam logic [4:0] S_A_FETCH  = 5'd11;
  localparam logic [4:0] S_A_COMMIT = 5'd12;
  localparam logic [4:0] S_RB_RD    = 5'd13;
  localparam logic [4:0] S_RB_APPLY = 5'd14;
  localparam logic [4:0] S_Q_RD     = 5'd15;
  localparam logic [4:0] S_Q_MUL    = 5'd16;
  localparam logic [4:0] S_Q_ADD    = 5'd17;
  localparam logic [4:0] S_Q_STEP   = 5'd18;
  localparam logic [4:0] S_Q_CHK    = 5'd19;
  localparam logic [4:0] S_DONE     = 5'd20;

  logic [4:0] state_q, state_d;
  logic [1:0] stat_q, stat_d;
  logic       first_q, first_d;
  logic       valid_q, valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    first_d = first_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        stat_d = chtr_pkg::STAT_OK;
        unique case (sts_i.kind)
          chtr_pkg::KIND_ADD: begin
            cmd_o.add_init = 1'b1;
            state_d        = sts_i.cnt_lt2 ? S_A_FETCH : S_A_RD;
          end
          chtr_pkg::KIND_UNDO: begin
            if (sts_i.undo_empty) begin
              stat_d  = chtr_pkg::STAT_NO_UNDO;
              state_d = S_DONE;
            end else begin
              state_d = S_RB_RD;
            end
          end
          chtr_pkg::KIND_QUERY: begin
            if (sts_i.cnt_zero) begin
              stat_d  = chtr_pkg::STAT_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.qry_init = 1'b1;
              first_d        = 1'b1;
              state_d        = S_Q_RD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      // add search step: read pair, normalize, four partial products
      S_A_RD: begin
        cmd_o.rd_sel = chtr_pkg::RD_PAIR;
        state_d      = S_A_NORM;
      end
      S_A_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_A_M0;
      end
      S_A_M0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_idx = 2'd0;
        state_d       = S_A_M1;
      end
      S_A_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_idx = 2'd1;
        cmd_o.acc_en  = 1'b1;
        state_d       = S_A_M2;
      end
      S_A_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_idx = 2'd2;
        cmd_o.acc_en  = 1'b1;
        state_d       = S_A_M3;
      end
      S_A_M3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_idx = 2'd3;
        cmd_o.acc_en  = 1'b1;
        state_d       = S_A_M4;
      end
      S_A_M4: begin
        cmd_o.acc_en = 1'b1;
        state_d      = S_A_DEC;
      end
      S_A_DEC: begin
        cmd_o.add_dec = 1'b1;
        state_d       = S_A_CHK;
      end
      S_A_CHK: begin
        state_d = sts_i.add_more ? S_A_RD : S_A_FETCH;
      end
      // add commit: fetch old slot, then write undo entry and new line
      S_A_FETCH: begin
        if (sts_i.add_full) begin
          stat_d  = chtr_pkg::STAT_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_sel = chtr_pkg::RD_POS;
          state_d      = S_A_COMMIT;
        end
      end
      S_A_COMMIT: begin
        cmd_o.add_commit = 1'b1;
        state_d          = S_DONE;
      end
      // rollback
      S_RB_RD: begin
        cmd_o.rb_rd = 1'b1;
        state_d     = S_RB_APPLY;
      end
      S_RB_APPLY: begin
        cmd_o.rb_apply = 1'b1;
        state_d        = S_DONE;
      end
      // query step: read, multiply, add, compare
      S_Q_RD: begin
        cmd_o.rd_sel = first_q ? chtr_pkg::RD_ZERO : chtr_pkg::RD_PAIR;
        state_d      = S_Q_MUL;
      end
      S_Q_MUL: begin
        cmd_o.ev_mul = 1'b1;
        state_d      = S_Q_ADD;
      end
      S_Q_ADD: begin
        cmd_o.ev_add = 1'b1;
        state_d      = S_Q_STEP;
      end
      S_Q_STEP: begin
        if (first_q) cmd_o.q_init = 1'b1;
        else         cmd_o.q_step = 1'b1;
        first_d = 1'b0;
        state_d = S_Q_CHK;
      end
      S_Q_CHK: begin
        state_d = sts_i.q_more ? S_Q_RD : S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!valid_q || rsp_ready_i) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = stat_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid
  always_comb begin
    if (cmd_o.out_load)   valid_d = 1'b1;
    else if (rsp_ready_i) valid_d = 1'b0;
    else                  valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stat_q  <= chtr_pkg::STAT_OK;
      first_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
      first_q <= first_d;
      valid_q <= valid_d;
    end
  end

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = valid_q;

endmodule

// ===== sv/convex_hull_trick_rollback.sv =====
// top level: convex hull trick line store with undo, request/result channels and register port

// Keeps lines on a convex hull (slopes arrive sorted) with an undo history and
// handles one request at a time: add a line, roll back the last add, or query
// the envelope at x. An add binary-searches the hull; each search step reads
// two lines through the two-port line store and compares two crossings exactly
// through a shared 33x18 multiplier in four partial products. A query step
// reads, multiplies, adds and compares. A rollback reads the last undo entry
// and then restores it. The result register lets a new request be taken while
// a result waits. No clearing pass runs after reset: slots at or beyond the
// hull count are never read back into a result. The lower-envelope select
// lives at byte address 0 and the decreasing-slope flag at 4.
module convex_hull_trick_rollback #(
  parameter int unsigned MAX_LINES  = 1024,
  parameter int unsigned UNDO_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  chtr_req_if.sink                        req_i,
  chtr_rsp_if.source                      rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [chtr_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned CW = $clog2(MAX_LINES + 1);

  chtr_pkg::cmd_t cmd;
  chtr_pkg::sts_t sts;
  logic           lower_env_q, decr_q;
  logic           cfg_we;
  logic [CW-1:0]  hull_size;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_env_q <= 1'b1;
      decr_q      <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2] == chtr_pkg::REG_LOWER_ENV) lower_env_q <= pwdata[0];
      else                                     decr_q      <= pwdata[0];
    end
  end

  assign prdata = {31'd0, (paddr[2] == chtr_pkg::REG_DECR) ? decr_q : lower_env_q};

  chtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  chtr_dp #(
    .MAX_LINES  (MAX_LINES),
    .UNDO_DEPTH (UNDO_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .lower_env_i (lower_env_q),
    .decr_i      (decr_q),
    .kind_i      (req_i.kind),
    .slope_i     (req_i.slope),
    .intercept_i (req_i.intercept),
    .point_x_i   (req_i.point_x),
    .value_o     (rsp_o.value),
    .hull_size_o (hull_size),
    .status_o    (rsp_o.status)
  );

  assign rsp_o.hull_size = hull_size;

  // an empty-hull query reports zero and an empty hull
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == chtr_pkg::STAT_EMPTY)
      |-> (rsp_o.value == '0) && (hull_size == '0))
    else $error("empty query result not zero");

  // a taken request blocks the next one
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while busy");

  // hull size never exceeds the store
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> hull_size <= CW'(MAX_LINES))
    else $error("hull size out of range");

  // only queries carry a nonzero value
  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != chtr_pkg::STAT_OK) |-> rsp_o.value == '0)
    else $error("value on refused request");

endmodule
